// ===== sv/dbc_pkg.sv =====
// shared types and constants for the double-byte code to glyph index block
// no dependencies; used by dbc_map and the top level
`timescale 1ns / 1ps

package dbc_pkg;

  localparam int GlyphW = 15;
  localparam int KindW  = 2;

  // character kind codes
  localparam logic [KindW-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KindW-1:0] KIND_DOUBLE = 2'd1;
  localparam logic [KindW-1:0] KIND_SKIP   = 2'd2;

  localparam logic [7:0] SKIP_BYTE = 8'h08;

  localparam logic [GlyphW-1:0] ROW_LEN        = 15'd94;
  localparam logic [GlyphW-1:0] EXT_A_ROW      = 15'd178;
  localparam logic [GlyphW-1:0] EXT_B_ROW      = 15'd84;
  localparam logic [GlyphW-1:0] EXT_A_BASE     = 15'd8742;
  localparam logic [GlyphW-1:0] EXT_B_BASE     = 15'd14438;
  localparam logic [GlyphW-1:0] UNMAPPED_GLYPH = 15'h60;
  localparam logic [GlyphW-1:0] DOUBLE_OFFSET  = 15'd256;
  localparam logic [GlyphW-1:0] GLYPH_MAX      = 15'd17885;

  typedef struct packed {
    logic [GlyphW-1:0] glyph_index;
    logic [KindW-1:0]  char_kind;
  } glyph_t;

endpackage

// ===== sv/dbc_map.sv =====
// combinational classifier and glyph index mapping for one byte pair
// depends on dbc_pkg
`timescale 1ns / 1ps

module dbc_map (
  input  logic [7:0]     lead_byte,
  input  logic [7:0]     trail_byte,
  output dbc_pkg::glyph_t result
);

  logic       trail_ok;
  logic       is_double;
  logic       main_area;
  logic       ext_a_area;
  logic       ext_b_area;
  logic [6:0] col_main;
  logic [6:0] row_main;
  logic [7:0] ext_col;
  logic [7:0] lead_a;
  logic [7:0] lead_b;
  logic [dbc_pkg::GlyphW-1:0] main_idx;
  logic [dbc_pkg::GlyphW-1:0] ext_a_idx;
  logic [dbc_pkg::GlyphW-1:0] ext_b_idx;
  logic [dbc_pkg::GlyphW-1:0] dbl_idx;

  always_comb begin
    trail_ok = (trail_byte >= 8'h41 && trail_byte <= 8'h5A) ||
               (trail_byte >= 8'h61 && trail_byte <= 8'h7A) ||
               (trail_byte >= 8'h81 && trail_byte <= 8'hFE);
    is_double = lead_byte >= 8'h81 && lead_byte <= 8'hFE && trail_ok;

    main_area  = lead_byte >= 8'hA1 && lead_byte <= 8'hFD && trail_byte >= 8'hA1;
    ext_a_area = lead_byte <= 8'hA0;
    ext_b_area = lead_byte >= 8'hA1 && lead_byte <= 8'hC6 && trail_byte <= 8'hA0;

    col_main = 7'(trail_byte - 8'hA1);

    // command rows sit first, then symbols, hangul, hanja
    if (lead_byte <= 8'hAC) begin
      row_main = 7'(lead_byte - 8'h9D);
    end else if (lead_byte <= 8'hAF) begin
      row_main = 7'(lead_byte - 8'hAD);
    end else if (lead_byte <= 8'hC8) begin
      row_main = 7'(lead_byte - 8'hA0);
    end else if (lead_byte == 8'hC9) begin
      row_main = 7'd3;
    end else begin
      row_main = 7'(lead_byte - 8'hA1);
    end

    // extension trail set: three runs packed back to back
    if (trail_byte <= 8'h5A) begin
      ext_col = trail_byte - 8'h41;
    end else if (trail_byte <= 8'h7A) begin
      ext_col = trail_byte - 8'h47;
    end else begin
      ext_col = trail_byte - 8'h4D;
    end

    lead_a = lead_byte - 8'h81;
    lead_b = lead_byte - 8'hA1;

    main_idx  = 15'(row_main) * dbc_pkg::ROW_LEN + 15'(col_main);
    ext_a_idx = 15'(lead_a) * dbc_pkg::EXT_A_ROW + 15'(ext_col) + dbc_pkg::EXT_A_BASE;
    ext_b_idx = 15'(lead_b) * dbc_pkg::EXT_B_ROW + 15'(ext_col) + dbc_pkg::EXT_B_BASE;

    if (main_area) begin
      dbl_idx = main_idx;
    end else if (ext_a_area) begin
      dbl_idx = ext_a_idx;
    end else if (ext_b_area) begin
      dbl_idx = ext_b_idx;
    end else begin
      dbl_idx = dbc_pkg::UNMAPPED_GLYPH;
    end

    if (lead_byte == dbc_pkg::SKIP_BYTE) begin
      result.glyph_index = '0;
      result.char_kind   = dbc_pkg::KIND_SKIP;
    end else if (is_double) begin
      result.glyph_index = dbl_idx + dbc_pkg::DOUBLE_OFFSET;
      result.char_kind   = dbc_pkg::KIND_DOUBLE;
    end else begin
      result.glyph_index = {7'd0, lead_byte};
      result.char_kind   = dbc_pkg::KIND_SINGLE;
    end
  end

endmodule

// ===== sv/double_byte_code_to_glyph_index_top.sv =====
// Takes one byte pair per item (byte at the text position and the byte after
// it) and returns its glyph number and kind: single-byte, double-byte or skip
// marker. One item is accepted every clock cycle unless the output stalls. The
// input register and the result register hold the mapping logic between them,
// so a result is registered in the result register after its item passes the
// input register. Both stages hold their item while the output is stalled.
// depends on dbc_pkg and dbc_map
`timescale 1ns / 1ps

module double_byte_code_to_glyph_index_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_lead_byte,
  input  logic [7:0]  in_trail_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_glyph_index,
  output logic [1:0]  out_char_kind
);

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_lead_r;
  logic [7:0] s1_trail_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_take;
  dbc_pkg::glyph_t map_res;
  dbc_pkg::glyph_t out_res_r;

  dbc_map u_map (
    .lead_byte  (s1_lead_r),
    .trail_byte (s1_trail_r),
    .result     (map_res)
  );

  // result register frees when empty or being taken
  assign out_take = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_take;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = out_take ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_lead_r  <= in_lead_byte;
      s1_trail_r <= in_trail_byte;
    end
    if (out_take && s1_valid_r) begin
      out_res_r <= map_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_glyph_index = out_res_r.glyph_index;
  assign out_char_kind   = out_res_r.char_kind;

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.char_kind == dbc_pkg::KIND_SKIP |-> out_res_r.glyph_index == '0)
    else $error("skip item with nonzero glyph");

  a_single_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.char_kind == dbc_pkg::KIND_SINGLE
      |-> out_res_r.glyph_index < dbc_pkg::DOUBLE_OFFSET)
    else $error("single-byte glyph out of range");

  a_double_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.char_kind == dbc_pkg::KIND_DOUBLE
      |-> out_res_r.glyph_index >= dbc_pkg::DOUBLE_OFFSET &&
          out_res_r.glyph_index <= dbc_pkg::GLYPH_MAX)
    else $error("double-byte glyph out of range");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_res_r.char_kind == dbc_pkg::KIND_SINGLE ||
                    out_res_r.char_kind == dbc_pkg::KIND_DOUBLE ||
                    out_res_r.char_kind == dbc_pkg::KIND_SKIP)
    else $error("undefined kind code");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_take |=> s1_valid_r && $stable(s1_lead_r) && $stable(s1_trail_r))
    else $error("input stage lost a stalled item");

endmodule
